>>> hdl/priority_bypass_circular_deque_macros.svh
// assertion macros shared by the deque modules
// no dependencies; taken in by `include in the modules that assert
`ifndef PRIORITY_BYPASS_CIRCULAR_DEQUE_MACROS_SVH
`define PRIORITY_BYPASS_CIRCULAR_DEQUE_MACROS_SVH

// same-cycle implication, checked outside reset
`define PBCD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define PBCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/pbcd_pkg.sv
// shared types and codes for the priority bypass circular deque
// no dependencies; imported by every module of the block
package pbcd_pkg;

   // opcodes of a request
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // response status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // threshold after reset
   localparam logic [6:0] THRESHOLD_RESET = 7'd60;

   // one stored entry
   typedef struct packed {
      logic [31:0] tag;
      logic [6:0]  priority_val;
   } entry_type;

   // control sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   // response load control from the sequencer to the output register
   typedef struct packed {
      logic       load;
      logic       use_mem;
      logic [1:0] status;
      logic [6:0] occupancy;
   } rsp_ctl_type;

endpackage

>>> hdl/pbcd_store.sv
// entry store: single write port, single read port, registered read data
// depends on pbcd_pkg for entry_type
module pbcd_store import pbcd_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_entry,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_entry
);

   entry_type mem_ff [DEPTH];
   entry_type rd_entry_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_entry;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

>>> hdl/pbcd_ctrl.sv
// deque sequencer: head/tail pointers, fill count and store accesses
// depends on pbcd_pkg and the assertion macro header
`include "priority_bypass_circular_deque_macros.svh"

module pbcd_ctrl import pbcd_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int CW    = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_opcode,
   input  logic [31:0]   req_item_tag,
   input  logic [6:0]    req_item_priority,
   input  logic [6:0]    threshold,
   input  logic          out_free,
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output entry_type     wr_entry,
   output logic          rd_en,
   output logic [AW-1:0] rd_addr,
   output rsp_ctl_type   rsp_ctl
);

   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   state_type     state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic          accept;
   logic          is_full;
   logic          is_empty;
   logic [AW-1:0] head_dec;
   logic [AW-1:0] head_inc;
   logic [AW-1:0] tail_inc;
   logic [31:0]   count_wide;

   assign is_full  = (count_ff == FULL_COUNT);
   assign is_empty = (count_ff == '0);
   assign head_dec = (head_ff == '0) ? LAST_SLOT : head_ff - 1'b1;
   assign head_inc = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
   assign tail_inc = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;

   // state and pointer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // next state, pointer updates and store accesses
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      req_ready = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_entry  = '{tag: req_item_tag, priority_val: req_item_priority};
      rd_en     = 1'b0;
      rd_addr   = head_ff;
      rsp_ctl   = '0;
      accept    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = out_free;
            accept    = req_valid && out_free;
            if (accept) begin
               rsp_ctl.load   = 1'b1;
               rsp_ctl.status = STATUS_OK;
               if (req_opcode == OP_INSERT) begin
                  if (is_full) begin
                     rsp_ctl.status = STATUS_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + 1'b1;
                     if (is_empty) begin
                        head_in = '0;
                        tail_in = '0;
                        wr_addr = '0;
                     end else if (req_item_priority >= threshold) begin
                        head_in = head_dec;
                        wr_addr = head_dec;
                     end else begin
                        tail_in = tail_inc;
                        wr_addr = tail_inc;
                     end
                  end
               end else if (is_empty) begin
                  rsp_ctl.status = STATUS_EMPTY;
               end else begin
                  // pop: read the head now, respond when the data returns
                  rsp_ctl.load = 1'b0;
                  rd_en        = 1'b1;
                  count_in     = count_ff - 1'b1;
                  state_in     = ST_READ;
                  if (head_ff == tail_ff) begin
                     head_in = '0;
                     tail_in = '0;
                  end else begin
                     head_in = head_inc;
                  end
               end
            end
            count_wide        = 32'(count_in);
            rsp_ctl.occupancy = count_wide[6:0];
         end
         ST_READ: begin
            rsp_ctl.load      = 1'b1;
            rsp_ctl.use_mem   = 1'b1;
            rsp_ctl.status    = STATUS_OK;
            count_wide        = 32'(count_ff);
            rsp_ctl.occupancy = count_wide[6:0];
            state_in          = ST_IDLE;
         end
         default: begin
            count_wide = '0;
            state_in   = ST_IDLE;
         end
      endcase
   end

   // sequencer checks
   `PBCD_ASSERT_NOW(a_read_blocks_req, clock, reset, state_ff == ST_READ, !req_ready, "request taken during store read")
   `PBCD_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= FULL_COUNT, "fill count beyond depth")
   `PBCD_ASSERT_NOW(a_empty_ptrs, clock, reset, count_ff == '0, (head_ff == '0) && (tail_ff == '0), "empty deque with pointers off slot zero")
   `PBCD_ASSERT_NEXT(a_pop_reads, clock, reset, rd_en, state_ff == ST_READ, "pop without a response cycle")

endmodule

>>> hdl/priority_bypass_circular_deque.sv
// Bounded circular deque of DEPTH entries (32-bit tag, 7-bit priority) with a priority bypass:
// an insert whose priority is at or above the threshold goes in at the head, others at the tail;
// a remove pops the head. Every request gives one response with status, popped entry and
// occupancy. Inserts and removes on an empty deque are taken back to back; a remove that pops
// is answered after the store read, because the entry store's read port registers its data
// and req_ready stays low while that read is out. The response register frees the
// request side: a new request is taken in the same cycle a waiting response is transferred.
// The store needs no clearing after reset; only written slots are ever popped. The threshold
// register (csr_priority_threshold, reset 60) may be written in any cycle and applies to the
// next insert. Depends on pbcd_pkg, pbcd_ctrl, pbcd_store and the assertion macro header.
`include "priority_bypass_circular_deque_macros.svh"

module priority_bypass_circular_deque import pbcd_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [31:0] req_item_tag,
   input  logic [6:0]  req_item_priority,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_out_tag,
   output logic [6:0]  rsp_out_priority,
   output logic [6:0]  rsp_occupancy,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_priority_threshold
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic          threshold_ff;
   logic [6:0]    threshold_val_ff;
   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff;
   logic [31:0]   rsp_tag_ff;
   logic [6:0]    rsp_prio_ff;
   logic [6:0]    rsp_occ_ff;
   logic          out_free;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_entry;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   entry_type     rd_entry;
   rsp_ctl_type   rsp_ctl;

   // threshold register, always writable
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff     <= 1'b0;
         threshold_val_ff <= THRESHOLD_RESET;
      end else if (csr_valid) begin
         threshold_ff     <= 1'b1;
         threshold_val_ff <= csr_priority_threshold;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   pbcd_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_item_tag      (req_item_tag),
      .req_item_priority (req_item_priority),
      .threshold         (threshold_val_ff),
      .out_free          (out_free),
      .wr_en             (wr_en),
      .wr_addr           (wr_addr),
      .wr_entry          (wr_entry),
      .rd_en             (rd_en),
      .rd_addr           (rd_addr),
      .rsp_ctl           (rsp_ctl)
   );

   pbcd_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_ctl.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (rsp_ctl.load) begin
         rsp_status_ff <= rsp_ctl.status;
         rsp_occ_ff    <= rsp_ctl.occupancy;
         rsp_tag_ff    <= rsp_ctl.use_mem ? rd_entry.tag : '0;
         rsp_prio_ff   <= rsp_ctl.use_mem ? rd_entry.priority_val : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_tag      = rsp_tag_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_occupancy    = rsp_occ_ff;

   // response register checks
   `PBCD_ASSERT_NOW(a_no_overwrite, clock, reset, rsp_ctl.load, out_free, "response overwritten before transfer")
   `PBCD_ASSERT_NOW(a_pop_ok, clock, reset, rsp_ctl.load && rsp_ctl.use_mem, rsp_ctl.status == STATUS_OK, "popped entry with error status")
   `PBCD_ASSERT_NEXT(a_load_valid, clock, reset, rsp_ctl.load, rsp_valid_ff, "loaded response not presented")
   `PBCD_ASSERT_NEXT(a_csr_taken, clock, reset, csr_valid, threshold_ff, "threshold write not recorded")

endmodule
